FILE: src/mse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg: shared definitions for the 6502 subset execute unit
// Action codes, operand width and register reset values.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int unsigned ACTION_W = 6;
    localparam int unsigned DATA_W   = 8;

    // load / compare / arithmetic / logic
    localparam logic [ACTION_W-1:0] ACT_LDA = 6'd0;
    localparam logic [ACTION_W-1:0] ACT_LDX = 6'd1;
    localparam logic [ACTION_W-1:0] ACT_LDY = 6'd2;
    localparam logic [ACTION_W-1:0] ACT_CMP = 6'd3;
    localparam logic [ACTION_W-1:0] ACT_CPX = 6'd4;
    localparam logic [ACTION_W-1:0] ACT_CPY = 6'd5;
    localparam logic [ACTION_W-1:0] ACT_ADC = 6'd6;
    localparam logic [ACTION_W-1:0] ACT_SBC = 6'd7;
    localparam logic [ACTION_W-1:0] ACT_AND = 6'd8;
    localparam logic [ACTION_W-1:0] ACT_ORA = 6'd9;
    localparam logic [ACTION_W-1:0] ACT_EOR = 6'd10;
    // increment / decrement
    localparam logic [ACTION_W-1:0] ACT_INX = 6'd11;
    localparam logic [ACTION_W-1:0] ACT_DEX = 6'd12;
    localparam logic [ACTION_W-1:0] ACT_INY = 6'd13;
    localparam logic [ACTION_W-1:0] ACT_DEY = 6'd14;
    // flag set / clear
    localparam logic [ACTION_W-1:0] ACT_SEC = 6'd15;
    localparam logic [ACTION_W-1:0] ACT_CLC = 6'd16;
    localparam logic [ACTION_W-1:0] ACT_SEI = 6'd17;
    localparam logic [ACTION_W-1:0] ACT_CLI = 6'd18;
    localparam logic [ACTION_W-1:0] ACT_SED = 6'd19;
    localparam logic [ACTION_W-1:0] ACT_CLD = 6'd20;
    localparam logic [ACTION_W-1:0] ACT_CLV = 6'd21;
    // transfers and no-op
    localparam logic [ACTION_W-1:0] ACT_TAX = 6'd22;
    localparam logic [ACTION_W-1:0] ACT_TAY = 6'd23;
    localparam logic [ACTION_W-1:0] ACT_TXA = 6'd24;
    localparam logic [ACTION_W-1:0] ACT_TYA = 6'd25;
    localparam logic [ACTION_W-1:0] ACT_TSX = 6'd26;
    localparam logic [ACTION_W-1:0] ACT_TXS = 6'd27;
    localparam logic [ACTION_W-1:0] ACT_NOP = 6'd28;
    // branch queries
    localparam logic [ACTION_W-1:0] ACT_BCC = 6'd29;
    localparam logic [ACTION_W-1:0] ACT_BCS = 6'd30;
    localparam logic [ACTION_W-1:0] ACT_BEQ = 6'd31;
    localparam logic [ACTION_W-1:0] ACT_BNE = 6'd32;
    localparam logic [ACTION_W-1:0] ACT_BMI = 6'd33;
    localparam logic [ACTION_W-1:0] ACT_BPL = 6'd34;
    localparam logic [ACTION_W-1:0] ACT_BVC = 6'd35;
    localparam logic [ACTION_W-1:0] ACT_BVS = 6'd36;
    localparam logic [ACTION_W-1:0] ACT_BRA = 6'd37;
    localparam logic [ACTION_W-1:0] ACT_BXX = 6'd38;

    // register reset values
    localparam logic [DATA_W-1:0] REG_RESET = 8'h00;
    localparam logic [DATA_W-1:0] SP_RESET  = 8'hFF;

endpackage
`default_nettype wire

FILE: src/mos6502_subset_execute_unit_core.sv
`default_nettype none
// Path: a word accepted at s_ passes through the input register, then is executed
// into the register file / result register before it is offered on m_.
// Throughput: one word per cycle while m_ready does not hold the result; the
// register-file update path through the 8-bit ALU sets this figure.
// Reset: synchronous active-low aresetn clears A, X, Y and all flags, sets SP
// to 0xFF and empties both stages.
// ----------------------------------------------------------------------------
// mos6502_subset_execute_unit_core
// Executes one 6502 subset instruction per word against A/X/Y/SP/NVDIZC.
// ----------------------------------------------------------------------------
module mos6502_subset_execute_unit_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mse_pkg::ACTION_W-1:0] s_action,
    input  wire logic [mse_pkg::DATA_W-1:0]  s_operand,
    input  wire logic                        s_immediate,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mse_pkg::DATA_W-1:0]       m_a_value,
    output logic [mse_pkg::DATA_W-1:0]       m_x_value,
    output logic [mse_pkg::DATA_W-1:0]       m_y_value,
    output logic [mse_pkg::DATA_W-1:0]       m_sp_value,
    output logic                             m_neg_flag,
    output logic                             m_ovf_flag,
    output logic                             m_dec_flag,
    output logic                             m_irq_mask_flag,
    output logic                             m_zero_flag,
    output logic                             m_carry_flag,
    output logic                             m_branch_taken,
    output logic                             m_unknown_branch
);

    localparam int unsigned DW = mse_pkg::DATA_W;

    // input stage
    logic                          in_valid_reg;
    logic [mse_pkg::ACTION_W-1:0]  in_action_reg;
    logic [DW-1:0]                 in_operand_reg;
    logic                          in_imm_reg;

    // register file, which doubles as the result register
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] x_reg, x_next;
    logic [DW-1:0] y_reg, y_next;
    logic [DW-1:0] sp_reg, sp_next;
    logic n_reg, n_next, v_reg, v_next, d_reg, d_next;
    logic i_reg, i_next, z_reg, z_next, c_reg, c_next;
    logic taken_reg, taken_next, unknown_reg, unknown_next;
    logic out_valid_reg;

    logic exec_fire;
    logic in_fire;

    // ALU intermediates
    logic [DW:0]   adc_sum;
    logic [DW:0]   sbc_diff;
    logic          adc_ovf, sbc_ovf;
    logic [DW-1:0] cmp_src;
    logic [DW:0]   cmp_diff;
    logic [DW-1:0] nz_val;
    logic          nz_upd;

    // handshake: execute when the result slot is free or being drained
    assign exec_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || exec_fire;
    assign in_fire   = s_valid && s_ready;

    // hold the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (in_fire) begin
            in_action_reg  <= s_action;
            in_operand_reg <= s_operand;
            in_imm_reg     <= s_immediate;
        end
    end

    // shared adder paths
    always_comb begin
        adc_sum  = {1'b0, a_reg} + {1'b0, in_operand_reg} + {{DW{1'b0}}, c_reg};
        adc_ovf  = ((a_reg[DW-1] ^ adc_sum[DW-1]) & (in_operand_reg[DW-1] ^ adc_sum[DW-1]));
        sbc_diff = {1'b0, a_reg} - {1'b0, in_operand_reg} - {{DW{1'b0}}, !c_reg};
        sbc_ovf  = ((a_reg[DW-1] ^ in_operand_reg[DW-1]) & (a_reg[DW-1] ^ sbc_diff[DW-1]));
        case (in_action_reg)
            mse_pkg::ACT_CPX: cmp_src = x_reg;
            mse_pkg::ACT_CPY: cmp_src = y_reg;
            default:          cmp_src = a_reg;
        endcase
        cmp_diff = {1'b0, cmp_src} - {1'b0, in_operand_reg};
    end

    // decode and compute next register file
    always_comb begin
        a_next       = a_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        sp_next      = sp_reg;
        n_next       = n_reg;
        v_next       = v_reg;
        d_next       = d_reg;
        i_next       = i_reg;
        z_next       = z_reg;
        c_next       = c_reg;
        taken_next   = 1'b0;
        unknown_next = 1'b0;
        nz_val       = {DW{1'b0}};
        nz_upd       = 1'b0;
        case (in_action_reg)
            mse_pkg::ACT_LDA: if (in_imm_reg) begin
                a_next = in_operand_reg; nz_val = in_operand_reg; nz_upd = 1'b1;
            end
            mse_pkg::ACT_LDX: if (in_imm_reg) begin
                x_next = in_operand_reg; nz_val = in_operand_reg; nz_upd = 1'b1;
            end
            mse_pkg::ACT_LDY: if (in_imm_reg) begin
                y_next = in_operand_reg; nz_val = in_operand_reg; nz_upd = 1'b1;
            end
            mse_pkg::ACT_CMP, mse_pkg::ACT_CPX, mse_pkg::ACT_CPY: if (in_imm_reg) begin
                c_next = !cmp_diff[DW]; nz_val = cmp_diff[DW-1:0]; nz_upd = 1'b1;
            end
            mse_pkg::ACT_ADC: if (in_imm_reg) begin
                a_next = adc_sum[DW-1:0]; c_next = adc_sum[DW]; v_next = adc_ovf;
                nz_val = adc_sum[DW-1:0]; nz_upd = 1'b1;
            end
            mse_pkg::ACT_SBC: if (in_imm_reg) begin
                a_next = sbc_diff[DW-1:0]; c_next = !sbc_diff[DW]; v_next = sbc_ovf;
                nz_val = sbc_diff[DW-1:0]; nz_upd = 1'b1;
            end
            mse_pkg::ACT_AND: if (in_imm_reg) begin
                a_next = a_reg & in_operand_reg; nz_val = a_next; nz_upd = 1'b1;
            end
            mse_pkg::ACT_ORA: if (in_imm_reg) begin
                a_next = a_reg | in_operand_reg; nz_val = a_next; nz_upd = 1'b1;
            end
            mse_pkg::ACT_EOR: if (in_imm_reg) begin
                a_next = a_reg ^ in_operand_reg; nz_val = a_next; nz_upd = 1'b1;
            end
            mse_pkg::ACT_INX: begin
                x_next = x_reg + 8'd1; nz_val = x_next; nz_upd = 1'b1;
            end
            mse_pkg::ACT_DEX: begin
                x_next = x_reg - 8'd1; nz_val = x_next; nz_upd = 1'b1;
            end
            mse_pkg::ACT_INY: begin
                y_next = y_reg + 8'd1; nz_val = y_next; nz_upd = 1'b1;
            end
            mse_pkg::ACT_DEY: begin
                y_next = y_reg - 8'd1; nz_val = y_next; nz_upd = 1'b1;
            end
            mse_pkg::ACT_SEC: c_next = 1'b1;
            mse_pkg::ACT_CLC: c_next = 1'b0;
            mse_pkg::ACT_SEI: i_next = 1'b1;
            mse_pkg::ACT_CLI: i_next = 1'b0;
            mse_pkg::ACT_SED: d_next = 1'b1;
            mse_pkg::ACT_CLD: d_next = 1'b0;
            mse_pkg::ACT_CLV: v_next = 1'b0;
            mse_pkg::ACT_TAX: begin
                x_next = a_reg; nz_val = a_reg; nz_upd = 1'b1;
            end
            mse_pkg::ACT_TAY: begin
                y_next = a_reg; nz_val = a_reg; nz_upd = 1'b1;
            end
            mse_pkg::ACT_TXA: begin
                a_next = x_reg; nz_val = x_reg; nz_upd = 1'b1;
            end
            mse_pkg::ACT_TYA: begin
                a_next = y_reg; nz_val = y_reg; nz_upd = 1'b1;
            end
            mse_pkg::ACT_TSX: begin
                x_next = sp_reg; nz_val = sp_reg; nz_upd = 1'b1;
            end
            // TXS leaves the flags alone
            mse_pkg::ACT_TXS: sp_next = x_reg;
            mse_pkg::ACT_BCC: taken_next = !c_reg;
            mse_pkg::ACT_BCS: taken_next = c_reg;
            mse_pkg::ACT_BEQ: taken_next = z_reg;
            mse_pkg::ACT_BNE: taken_next = !z_reg;
            mse_pkg::ACT_BMI: taken_next = n_reg;
            mse_pkg::ACT_BPL: taken_next = !n_reg;
            mse_pkg::ACT_BVC: taken_next = !v_reg;
            mse_pkg::ACT_BVS: taken_next = v_reg;
            mse_pkg::ACT_BRA: taken_next = 1'b1;
            mse_pkg::ACT_BXX: unknown_next = 1'b1;
            default: ;
        endcase
        if (nz_upd) begin
            z_next = (nz_val == {DW{1'b0}});
            n_next = nz_val[DW-1];
        end
    end

    // advance the register file and the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg         <= mse_pkg::REG_RESET;
            x_reg         <= mse_pkg::REG_RESET;
            y_reg         <= mse_pkg::REG_RESET;
            sp_reg        <= mse_pkg::SP_RESET;
            n_reg         <= 1'b0;
            v_reg         <= 1'b0;
            d_reg         <= 1'b0;
            i_reg         <= 1'b0;
            z_reg         <= 1'b0;
            c_reg         <= 1'b0;
            taken_reg     <= 1'b0;
            unknown_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (exec_fire) begin
                a_reg       <= a_next;
                x_reg       <= x_next;
                y_reg       <= y_next;
                sp_reg      <= sp_next;
                n_reg       <= n_next;
                v_reg       <= v_next;
                d_reg       <= d_next;
                i_reg       <= i_next;
                z_reg       <= z_next;
                c_reg       <= c_next;
                taken_reg   <= taken_next;
                unknown_reg <= unknown_next;
            end
            if (exec_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_a_value        = a_reg;
    assign m_x_value        = x_reg;
    assign m_y_value        = y_reg;
    assign m_sp_value       = sp_reg;
    assign m_neg_flag       = n_reg;
    assign m_ovf_flag       = v_reg;
    assign m_dec_flag       = d_reg;
    assign m_irq_mask_flag  = i_reg;
    assign m_zero_flag      = z_reg;
    assign m_carry_flag     = c_reg;
    assign m_branch_taken   = taken_reg;
    assign m_unknown_branch = unknown_reg;

    // check: reset leaves SP at its reset value and both stages empty
    assert property (@(posedge aclk) !aresetn |=>
        (m_sp_value == mse_pkg::SP_RESET) && !m_valid && s_ready)
        else $error("reset state wrong");

    // check: unknown branch never reports taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_unknown_branch && m_branch_taken))
        else $error("unknown branch reported taken");

    // check: a branch query changes no register
    assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && (in_action_reg >= mse_pkg::ACT_BCC) |=>
        $stable(a_reg) && $stable(x_reg) && $stable(y_reg) && $stable(sp_reg))
        else $error("branch query changed registers");

    // check: input stalls only while a word is held in the input stage and the result is not drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without cause");

endmodule
`default_nettype wire
